// ===== rtl/prpc_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Paired read pair classifier package
// Shared widths, register codes, class codes and reset values.
// ---------------------------------------------------------------------------
package prpc_pkg;

   localparam int OFFSET_BITS_DEFAULT = 36;
   localparam int LENGTH_BITS_DEFAULT = 16;

   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 20;
   localparam int FRAG_BITS      = 20;
   localparam int CLASS_BITS     = 3;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_ORIENTATION_POLICY = 3'd0,
      CSR_MAX_FRAGMENT       = 3'd1,
      CSR_MIN_FRAGMENT       = 3'd2,
      CSR_EXPAND_TO_FIT      = 3'd3,
      CSR_OVERLAP_ALLOWED    = 3'd4,
      CSR_CONTAIN_ALLOWED    = 3'd5,
      CSR_DOVETAIL_ALLOWED   = 3'd6
   } csr_index_type;

   typedef enum logic [1:0] {
      POLICY_FF = 2'd0,
      POLICY_RR = 2'd1,
      POLICY_FR = 2'd2,
      POLICY_RF = 2'd3
   } policy_type;

   typedef enum logic [CLASS_BITS-1:0] {
      CLASS_NORMAL     = 3'd0,
      CLASS_OVERLAP    = 3'd1,
      CLASS_CONTAIN    = 3'd2,
      CLASS_DOVETAIL   = 3'd3,
      CLASS_DISCORDANT = 3'd4
   } pair_class_type;

   localparam policy_type       RESET_POLICY   = POLICY_FR;
   localparam logic [FRAG_BITS-1:0] RESET_MAX_FRAGMENT = 20'd500;
   localparam logic [FRAG_BITS-1:0] RESET_MIN_FRAGMENT = 20'd0;
   localparam logic RESET_EXPAND_TO_FIT    = 1'b1;
   localparam logic RESET_OVERLAP_ALLOWED  = 1'b1;
   localparam logic RESET_CONTAIN_ALLOWED  = 1'b1;
   localparam logic RESET_DOVETAIL_ALLOWED = 1'b0;

endpackage

// ===== rtl/prpc_if.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Paired read pair classifier channels
// Valid/ready channels for alignment pairs, classes and register writes.
// ---------------------------------------------------------------------------
interface prpc_req_if #(
   parameter int OFFSET_BITS = prpc_pkg::OFFSET_BITS_DEFAULT,
   parameter int LENGTH_BITS = prpc_pkg::LENGTH_BITS_DEFAULT
);
   logic                          valid;
   logic                          ready;
   logic signed [OFFSET_BITS-1:0] first_offset;
   logic        [LENGTH_BITS-1:0] first_length;
   logic                          first_forward;
   logic signed [OFFSET_BITS-1:0] second_offset;
   logic        [LENGTH_BITS-1:0] second_length;
   logic                          second_forward;

   modport source (output valid, first_offset, first_length, first_forward,
                   second_offset, second_length, second_forward,
                   input ready);
   modport sink (input valid, first_offset, first_length, first_forward,
                 second_offset, second_length, second_forward,
                 output ready);
endinterface

interface prpc_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [prpc_pkg::CLASS_BITS-1:0]   pair_class;

   modport source (output valid, pair_class, input ready);
   modport sink (input valid, pair_class, output ready);
endinterface

interface prpc_csr_if;
   logic                                 valid;
   logic                                 ready;
   logic [prpc_pkg::CSR_INDEX_BITS-1:0]  index;
   logic [prpc_pkg::CSR_DATA_BITS-1:0]   data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/paired_read_pair_classifier.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Paired read pair classifier
// Classes one paired-end alignment per transfer as normal, overlap, contain,
// dovetail or discordant.
// ---------------------------------------------------------------------------
// A request transfer is registered in stage one, then in stage two, then in the
// result register, from which the class is offered on the result channel.
// Throughput: one pair per cycle; the three register stages (mate ends,
// ordering compares, fragment extent and class) advance together.
// A stalled result holds the whole pipeline without loss.
// Reset clears the stage valid bits and loads the register defaults.

module paired_read_pair_classifier #(
   parameter int OFFSET_BITS = prpc_pkg::OFFSET_BITS_DEFAULT,
   parameter int LENGTH_BITS = prpc_pkg::LENGTH_BITS_DEFAULT
) (
   input logic        clock,
   input logic        reset,
   prpc_req_if.sink   req_chan,
   prpc_rsp_if.source rsp_chan,
   prpc_csr_if.sink   csr_chan
);

   localparam int EW = ((OFFSET_BITS > LENGTH_BITS + 1) ? OFFSET_BITS : LENGTH_BITS + 1) + 1;
   localparam int MW = (prpc_pkg::FRAG_BITS > LENGTH_BITS) ? prpc_pkg::FRAG_BITS : LENGTH_BITS;
   localparam int CW = (EW > MW) ? EW : MW;

   // Register file.
   prpc_pkg::policy_type               policy_ff;
   logic [prpc_pkg::FRAG_BITS-1:0]     max_fragment_ff;
   logic [prpc_pkg::FRAG_BITS-1:0]     min_fragment_ff;
   logic                               expand_ff;
   logic                               overlap_ok_ff;
   logic                               contain_ok_ff;
   logic                               dovetail_ok_ff;

   logic advance;

   // Stage one.
   logic                 s1_valid_ff;
   logic signed [EW-1:0] s1_off1_ff, s1_off2_ff, s1_end1_ff, s1_end2_ff;
   logic                 s1_bad_ff, s1_one_left_ff;
   logic [MW-1:0]        s1_maxf_ff, s1_minf_ff;
   logic signed [EW-1:0] s1_off1_in, s1_off2_in, s1_end1_in, s1_end2_in;
   logic                 s1_bad_in, s1_one_left_in;
   logic [MW-1:0]        s1_maxf_in, s1_maxf_mid, s1_minf_in;

   // Stage two.
   logic                 s2_valid_ff;
   logic signed [EW-1:0] s2_flo_ff, s2_fhi_ff;
   logic                 s2_bad_ff, s2_contain_ff, s2_olap_ff, s2_order_ff, s2_dove_ff;
   logic [MW-1:0]        s2_maxf_ff, s2_minf_ff;
   logic signed [EW-1:0] s2_flo_in, s2_fhi_in;
   logic                 s2_contain_in, s2_olap_in, s2_order_in, s2_dove_in;
   logic                 lt12, lt21, e_lt12, e_lt21, e1_gt_o2, o1_lt_e2;

   // Stage three, the result register.
   logic                     s3_valid_ff;
   prpc_pkg::pair_class_type s3_class_ff, s3_class_in;
   logic signed [EW:0]       frag_diff;
   logic [CW-1:0]            frag_cmp;
   logic                     frag_bad;

   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         policy_ff       <= prpc_pkg::RESET_POLICY;
         max_fragment_ff <= prpc_pkg::RESET_MAX_FRAGMENT;
         min_fragment_ff <= prpc_pkg::RESET_MIN_FRAGMENT;
         expand_ff       <= prpc_pkg::RESET_EXPAND_TO_FIT;
         overlap_ok_ff   <= prpc_pkg::RESET_OVERLAP_ALLOWED;
         contain_ok_ff   <= prpc_pkg::RESET_CONTAIN_ALLOWED;
         dovetail_ok_ff  <= prpc_pkg::RESET_DOVETAIL_ALLOWED;
      end else if (csr_chan.valid) begin
         case (prpc_pkg::csr_index_type'(csr_chan.index))
            prpc_pkg::CSR_ORIENTATION_POLICY:
               policy_ff <= prpc_pkg::policy_type'(csr_chan.data[1:0]);
            prpc_pkg::CSR_MAX_FRAGMENT:     max_fragment_ff <= csr_chan.data;
            prpc_pkg::CSR_MIN_FRAGMENT:     min_fragment_ff <= csr_chan.data;
            prpc_pkg::CSR_EXPAND_TO_FIT:    expand_ff       <= csr_chan.data[0];
            prpc_pkg::CSR_OVERLAP_ALLOWED:  overlap_ok_ff   <= csr_chan.data[0];
            prpc_pkg::CSR_CONTAIN_ALLOWED:  contain_ok_ff   <= csr_chan.data[0];
            prpc_pkg::CSR_DOVETAIL_ALLOWED: dovetail_ok_ff  <= csr_chan.data[0];
            default: ;
         endcase
      end
   end

   // The whole pipeline moves when the result register is empty or being drained.
   assign advance        = !s3_valid_ff || rsp_chan.ready;
   assign req_chan.ready = advance;

   always_comb begin
      s1_off1_in = EW'(req_chan.first_offset);
      s1_off2_in = EW'(req_chan.second_offset);
      s1_end1_in = s1_off1_in + signed'(EW'(req_chan.first_length));
      s1_end2_in = s1_off2_in + signed'(EW'(req_chan.second_length));
      case (policy_ff)
         prpc_pkg::POLICY_FF,
         prpc_pkg::POLICY_RR: s1_bad_in = req_chan.first_forward != req_chan.second_forward;
         default:             s1_bad_in = req_chan.first_forward == req_chan.second_forward;
      endcase
      case (policy_ff)
         prpc_pkg::POLICY_FF,
         prpc_pkg::POLICY_FR: s1_one_left_in = req_chan.first_forward;
         default:             s1_one_left_in = !req_chan.first_forward;
      endcase
      s1_maxf_mid = MW'(max_fragment_ff);
      if (expand_ff && MW'(req_chan.first_length) > s1_maxf_mid) begin
         s1_maxf_mid = MW'(req_chan.first_length);
      end
      s1_maxf_in = s1_maxf_mid;
      if (expand_ff && MW'(req_chan.second_length) > s1_maxf_mid) begin
         s1_maxf_in = MW'(req_chan.second_length);
      end
      s1_minf_in = (min_fragment_ff == '0) ? MW'(1) : MW'(min_fragment_ff);
   end

   always_comb begin
      lt12     = s1_off1_ff < s1_off2_ff;
      lt21     = s1_off2_ff < s1_off1_ff;
      e_lt12   = s1_end1_ff < s1_end2_ff;
      e_lt21   = s1_end2_ff < s1_end1_ff;
      e1_gt_o2 = s1_end1_ff > s1_off2_ff;
      o1_lt_e2 = s1_off1_ff < s1_end2_ff;
      s2_flo_in     = lt12 ? s1_off1_ff : s1_off2_ff;
      s2_fhi_in     = e_lt21 ? s1_end1_ff : s1_end2_ff;
      s2_contain_in = (!lt12 && !e_lt21) || (!lt21 && !e_lt12);
      s2_olap_in    = (!lt21 && e1_gt_o2) || (o1_lt_e2 && !e_lt12) || s2_contain_in;
      s2_order_in   = s1_one_left_ff ? lt21 : lt12;
      s2_dove_in    = s1_one_left_ff ? (e_lt21 || lt21) : (e_lt12 || lt12);
   end

   always_comb begin
      frag_diff = (EW + 1)'(s2_fhi_ff) - (EW + 1)'(s2_flo_ff);
      frag_cmp  = CW'(frag_diff[EW-1:0]);
      frag_bad  = (frag_cmp > CW'(s2_maxf_ff)) || (frag_cmp < CW'(s2_minf_ff));
      if (s2_bad_ff || frag_bad) begin
         s3_class_in = prpc_pkg::CLASS_DISCORDANT;
      end else if (s2_olap_ff && !overlap_ok_ff) begin
         s3_class_in = prpc_pkg::CLASS_DISCORDANT;
      end else if (!s2_olap_ff && s2_order_ff) begin
         s3_class_in = prpc_pkg::CLASS_DISCORDANT;
      end else if (s2_contain_ff && !contain_ok_ff) begin
         s3_class_in = prpc_pkg::CLASS_DISCORDANT;
      end else if (s2_dove_ff && !dovetail_ok_ff) begin
         s3_class_in = prpc_pkg::CLASS_DISCORDANT;
      end else if (s2_dove_ff) begin
         s3_class_in = prpc_pkg::CLASS_DOVETAIL;
      end else if (s2_contain_ff) begin
         s3_class_in = prpc_pkg::CLASS_CONTAIN;
      end else if (s2_olap_ff) begin
         s3_class_in = prpc_pkg::CLASS_OVERLAP;
      end else begin
         s3_class_in = prpc_pkg::CLASS_NORMAL;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= req_chan.valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_off1_ff     <= s1_off1_in;
         s1_off2_ff     <= s1_off2_in;
         s1_end1_ff     <= s1_end1_in;
         s1_end2_ff     <= s1_end2_in;
         s1_bad_ff      <= s1_bad_in;
         s1_one_left_ff <= s1_one_left_in;
         s1_maxf_ff     <= s1_maxf_in;
         s1_minf_ff     <= s1_minf_in;
         s2_flo_ff      <= s2_flo_in;
         s2_fhi_ff      <= s2_fhi_in;
         s2_bad_ff      <= s1_bad_ff;
         s2_contain_ff  <= s2_contain_in;
         s2_olap_ff     <= s2_olap_in;
         s2_order_ff    <= s2_order_in;
         s2_dove_ff     <= s2_dove_in;
         s2_maxf_ff     <= s1_maxf_ff;
         s2_minf_ff     <= s1_minf_ff;
         s3_class_ff    <= s3_class_in;
      end
   end

   assign rsp_chan.valid      = s3_valid_ff;
   assign rsp_chan.pair_class = s3_class_ff;

endmodule

// ===== sim/tb_paired_read_pair_classifier.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Paired read pair classifier testbench
// Streams alignment pairs through the classifier and compares every class it
// returns with an independent prediction held in the bench. Register
// settings change only while the block is idle. The sender and the receiver
// idle at random, and one long hold on the result side fills the pipeline.
// ---------------------------------------------------------------------------
module tb_paired_read_pair_classifier;

   localparam int OFFSET_W = prpc_pkg::OFFSET_BITS_DEFAULT;
   localparam int LENGTH_W = prpc_pkg::LENGTH_BITS_DEFAULT;
   localparam logic [prpc_pkg::CSR_INDEX_BITS-1:0] CSR_UNUSED_INDEX = 3'd7;
   localparam int DRAIN_CYCLES  = 8;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int PHASE_PAIRS   = 100;
   localparam int HOLD_OFF_LENGTH = 80;

   typedef struct {
      logic signed [OFFSET_W-1:0] first_offset;
      logic        [LENGTH_W-1:0] first_length;
      logic                       first_forward;
      logic signed [OFFSET_W-1:0] second_offset;
      logic        [LENGTH_W-1:0] second_length;
      logic                       second_forward;
   } pair_item_type;

   logic clock = 1'b0;
   logic reset;

   prpc_req_if req_chan ();
   prpc_rsp_if rsp_chan ();
   prpc_csr_if csr_chan ();

   paired_read_pair_classifier uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Copy of the register file as the bench believes it to be.
   prpc_pkg::policy_type           cfg_policy;
   logic [prpc_pkg::FRAG_BITS-1:0] cfg_max_fragment;
   logic [prpc_pkg::FRAG_BITS-1:0] cfg_min_fragment;
   logic                           cfg_expand;
   logic                           cfg_overlap_ok;
   logic                           cfg_contain_ok;
   logic                           cfg_dovetail_ok;

   prpc_pkg::pair_class_type pending_classes[$];

   logic hold_off_start = 1'b0;

   int send_idle_pct   = 0;
   int recv_stall_pct  = 0;
   int hold_off_cycles = 0;
   int pairs_sent      = 0;
   int classes_checked = 0;
   int csr_transfers   = 0;
   int settings_used   = 0;
   int input_stalls    = 0;
   int mismatches      = 0;
   int quiet_cycles    = 0;

   function automatic prpc_pkg::pair_class_type classify_pair(input pair_item_type p);
      longint lo1, lo2, hi1, hi2, end1, end2, frag_lo, frag_hi, frag, limit_hi, limit_lo;
      logic   left_one;
      logic   has_contain;
      logic   has_overlap;
      prpc_pkg::pair_class_type verdict;
      verdict  = prpc_pkg::CLASS_NORMAL;
      limit_hi = longint'(cfg_max_fragment);
      limit_lo = longint'(cfg_min_fragment);
      if (cfg_expand && longint'(p.first_length) > limit_hi) begin
         limit_hi = longint'(p.first_length);
      end
      if (cfg_expand && longint'(p.second_length) > limit_hi) begin
         limit_hi = longint'(p.second_length);
      end
      if (limit_lo < 1) limit_lo = 1;

      if (cfg_policy == prpc_pkg::POLICY_FF || cfg_policy == prpc_pkg::POLICY_RR) begin
         if (p.first_forward != p.second_forward) return prpc_pkg::CLASS_DISCORDANT;
      end else begin
         if (p.first_forward == p.second_forward) return prpc_pkg::CLASS_DISCORDANT;
      end
      left_one = (cfg_policy == prpc_pkg::POLICY_FF || cfg_policy == prpc_pkg::POLICY_FR) ?
                 p.first_forward : !p.first_forward;

      lo1  = longint'(p.first_offset);
      lo2  = longint'(p.second_offset);
      end1 = lo1 + longint'(p.first_length);
      end2 = lo2 + longint'(p.second_length);
      frag_lo = (lo1 < lo2) ? lo1 : lo2;
      frag_hi = (end1 > end2) ? end1 : end2;
      frag    = frag_hi - frag_lo;
      if (frag > limit_hi || frag < limit_lo) return prpc_pkg::CLASS_DISCORDANT;

      hi1 = end1 - 1;
      hi2 = end2 - 1;
      has_contain = (lo1 >= lo2 && hi1 <= hi2) || (lo2 >= lo1 && hi2 <= hi1);
      has_overlap = (lo1 <= lo2 && hi1 >= lo2) || (lo1 <= hi2 && hi1 >= hi2) || has_contain;
      if (has_overlap) begin
         if (!cfg_overlap_ok) return prpc_pkg::CLASS_DISCORDANT;
         verdict = prpc_pkg::CLASS_OVERLAP;
      end else if ((left_one && lo2 < lo1) || (!left_one && lo1 < lo2)) begin
         return prpc_pkg::CLASS_DISCORDANT;
      end
      if (has_contain) begin
         if (!cfg_contain_ok) return prpc_pkg::CLASS_DISCORDANT;
         verdict = prpc_pkg::CLASS_CONTAIN;
      end
      if ((left_one && (hi1 > hi2 || lo2 < lo1)) || (!left_one && (hi2 > hi1 || lo1 < lo2))) begin
         if (!cfg_dovetail_ok) return prpc_pkg::CLASS_DISCORDANT;
         verdict = prpc_pkg::CLASS_DOVETAIL;
      end
      return verdict;
   endfunction

   function automatic pair_item_type make_pair(input longint off1, input int len1, input bit fw1,
                                               input longint off2, input int len2, input bit fw2);
      pair_item_type p;
      p.first_offset   = OFFSET_W'(off1);
      p.first_length   = LENGTH_W'(len1);
      p.first_forward  = fw1;
      p.second_offset  = OFFSET_W'(off2);
      p.second_length  = LENGTH_W'(len2);
      p.second_forward = fw2;
      return p;
   endfunction

   function automatic logic [LENGTH_W-1:0] random_length();
      if ($urandom_range(3) == 0) return LENGTH_W'($urandom_range(1, 65535));
      return LENGTH_W'($urandom_range(1, 300));
   endfunction

   // Most pairs sit close together with strands that suit the policy, so
   // that every class is reached; the rest are unrelated noise.
   function automatic pair_item_type random_pair();
      pair_item_type p;
      int            span;
      int            delta;
      p.first_offset = OFFSET_W'({$urandom(), $urandom()});
      if ($urandom_range(99) < 15) begin
         p.first_length   = LENGTH_W'($urandom_range(1, 65535));
         p.second_length  = LENGTH_W'($urandom_range(1, 65535));
         p.first_forward  = 1'($urandom_range(1));
         p.second_forward = 1'($urandom_range(1));
         p.second_offset  = OFFSET_W'({$urandom(), $urandom()});
         return p;
      end
      p.first_length  = random_length();
      p.second_length = random_length();
      if ($urandom_range(99) < 30) span = 300;
      else span = int'(cfg_max_fragment) + 200;
      delta = int'($urandom_range(0, 2 * span)) - span;
      p.second_offset = p.first_offset + OFFSET_W'(delta);
      case (cfg_policy)
         prpc_pkg::POLICY_FF: begin
            p.first_forward  = 1'b1;
            p.second_forward = 1'b1;
         end
         prpc_pkg::POLICY_RR: begin
            p.first_forward  = 1'b0;
            p.second_forward = 1'b0;
         end
         default: begin
            p.first_forward  = 1'($urandom_range(1));
            p.second_forward = !p.first_forward;
         end
      endcase
      if ($urandom_range(99) < 12) p.second_forward = !p.second_forward;
      return p;
   endfunction

   task automatic send_pair(input pair_item_type p);
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid          <= 1'b1;
      req_chan.first_offset   <= p.first_offset;
      req_chan.first_length   <= p.first_length;
      req_chan.first_forward  <= p.first_forward;
      req_chan.second_offset  <= p.second_offset;
      req_chan.second_length  <= p.second_length;
      req_chan.second_forward <= p.second_forward;
      do @(posedge clock); while (!req_chan.ready);
      pending_classes.push_back(classify_pair(p));
      pairs_sent++;
   endtask

   task automatic write_register(input logic [prpc_pkg::CSR_INDEX_BITS-1:0] index,
                                 input logic [prpc_pkg::CSR_DATA_BITS-1:0] value);
      csr_chan.valid <= 1'b1;
      csr_chan.index <= index;
      csr_chan.data  <= value;
      do @(posedge clock); while (!csr_chan.ready);
      csr_transfers++;
      case (index)
         prpc_pkg::CSR_ORIENTATION_POLICY:
            cfg_policy = prpc_pkg::policy_type'(value[1:0]);
         prpc_pkg::CSR_MAX_FRAGMENT:     cfg_max_fragment = value;
         prpc_pkg::CSR_MIN_FRAGMENT:     cfg_min_fragment = value;
         prpc_pkg::CSR_EXPAND_TO_FIT:    cfg_expand       = value[0];
         prpc_pkg::CSR_OVERLAP_ALLOWED:  cfg_overlap_ok   = value[0];
         prpc_pkg::CSR_CONTAIN_ALLOWED:  cfg_contain_ok   = value[0];
         prpc_pkg::CSR_DOVETAIL_ALLOWED: cfg_dovetail_ok  = value[0];
         default: ;
      endcase
   endtask

   task automatic load_settings(input prpc_pkg::policy_type pol, input int max_frag,
                                input int min_frag, input bit expand, input bit overlap_ok,
                                input bit contain_ok, input bit dovetail_ok);
      write_register(prpc_pkg::CSR_ORIENTATION_POLICY, prpc_pkg::CSR_DATA_BITS'(pol));
      write_register(prpc_pkg::CSR_MAX_FRAGMENT, prpc_pkg::CSR_DATA_BITS'(max_frag));
      write_register(prpc_pkg::CSR_MIN_FRAGMENT, prpc_pkg::CSR_DATA_BITS'(min_frag));
      write_register(prpc_pkg::CSR_EXPAND_TO_FIT, prpc_pkg::CSR_DATA_BITS'(expand));
      write_register(prpc_pkg::CSR_OVERLAP_ALLOWED, prpc_pkg::CSR_DATA_BITS'(overlap_ok));
      write_register(prpc_pkg::CSR_CONTAIN_ALLOWED, prpc_pkg::CSR_DATA_BITS'(contain_ok));
      write_register(prpc_pkg::CSR_DOVETAIL_ALLOWED, prpc_pkg::CSR_DATA_BITS'(dovetail_ok));
      csr_chan.valid <= 1'b0;
      settings_used++;
   endtask

   task automatic wait_for_results();
      req_chan.valid <= 1'b0;
      while (pending_classes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic test_reset_defaults();
      longint top;
      longint bottom;
      top    = (longint'(1) << (OFFSET_W - 1)) - 1;
      bottom = -(longint'(1) << (OFFSET_W - 1));
      send_pair(make_pair(100, 50, 1, 300, 50, 0));
      send_pair(make_pair(100, 100, 1, 150, 100, 0));
      send_pair(make_pair(100, 50, 1, 100, 200, 0));
      send_pair(make_pair(100, 200, 1, 150, 50, 0));
      send_pair(make_pair(200, 100, 1, 150, 100, 0));
      send_pair(make_pair(300, 50, 1, 100, 50, 0));
      send_pair(make_pair(100, 50, 1, 300, 50, 1));
      send_pair(make_pair(0, 10, 1, 1000, 10, 0));
      send_pair(make_pair(0, 10, 1, 490, 10, 0));
      send_pair(make_pair(0, 10, 1, 491, 10, 0));
      send_pair(make_pair(0, 10, 1, 0, 65535, 0));
      send_pair(make_pair(bottom, 1, 1, bottom + 10, 1, 0));
      send_pair(make_pair(top - 100, 50, 1, top, 1, 0));
      send_pair(make_pair(top, 65535, 1, top, 1, 0));
      // Empty mates: one at a shared offset gives no extent at all.
      send_pair(make_pair(100, 0, 1, 100, 0, 0));
      send_pair(make_pair(100, 0, 1, 100, 5, 0));
      send_pair(make_pair(5, 1, 1, 5, 1, 0));
      send_pair(make_pair(300, 50, 0, 100, 50, 1));
      wait_for_results();
   endtask

   task automatic test_case_switches();
      load_settings(prpc_pkg::POLICY_FR, 500, 0, 1, 1, 1, 1);
      send_pair(make_pair(200, 100, 1, 150, 100, 0));
      send_pair(make_pair(100, 200, 1, 150, 50, 0));
      wait_for_results();
      load_settings(prpc_pkg::POLICY_RF, 300, 20, 0, 0, 0, 0);
      send_pair(make_pair(150, 100, 1, 100, 100, 0));
      send_pair(make_pair(100, 200, 0, 100, 50, 1));
      send_pair(make_pair(0, 1000, 0, 0, 1000, 1));
      send_pair(make_pair(0, 5, 0, 10, 5, 1));
      wait_for_results();
   endtask

   task automatic test_unused_register_index();
      write_register(CSR_UNUSED_INDEX, '1);
      csr_chan.valid <= 1'b0;
      send_pair(make_pair(150, 100, 1, 100, 100, 0));
      send_pair(make_pair(200, 50, 0, 0, 50, 1));
      wait_for_results();
   endtask

   task automatic test_random_phases();
      int max_frag;
      for (int phase = 0; phase < 8; phase++) begin
         if (phase == 3) begin
            send_idle_pct  = 49;
            recv_stall_pct = 7;
         end else if (phase == 6) begin
            send_idle_pct  = 0;
            recv_stall_pct = 0;
         end
         case (phase)
            0: load_settings(prpc_pkg::POLICY_FF, 500, 0, 1, 1, 1, 0);
            1: load_settings(prpc_pkg::POLICY_RR, 1048575, 0, 0, 1, 1, 1);
            2: load_settings(prpc_pkg::POLICY_FR, 0, 0, 1, 1, 1, 1);
            3: load_settings(prpc_pkg::POLICY_RF, 2000, 100, 0, 1, 0, 1);
            4: load_settings(prpc_pkg::POLICY_FF, 1048575, 1048575, 1, 0, 1, 0);
            default: begin
               max_frag = $urandom_range(0, 4000);
               load_settings(prpc_pkg::policy_type'($urandom_range(3)), max_frag,
                             $urandom_range(0, max_frag), 1'($urandom_range(1)),
                             1'($urandom_range(1)), 1'($urandom_range(1)),
                             1'($urandom_range(1)));
            end
         endcase
         repeat (PHASE_PAIRS) send_pair(random_pair());
         wait_for_results();
      end
   endtask

   task automatic test_backpressure();
      hold_off_start <= 1'b1;
      @(posedge clock);
      hold_off_start <= 1'b0;
      repeat (30) send_pair(random_pair());
      wait_for_results();
   endtask

   // Long hold-off on the result side, counted here in cycles.
   always @(posedge clock) begin
      if (hold_off_start) begin
         hold_off_cycles <= HOLD_OFF_LENGTH;
      end else if (hold_off_cycles > 0) begin
         hold_off_cycles <= hold_off_cycles - 1;
      end
   end

   // Result side: ready pattern and the class check.
   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         classes_checked++;
         if (pending_classes.size() == 0) begin
            $error("pair_class: no class expected, got %0d", rsp_chan.pair_class);
            mismatches++;
         end else if (pending_classes[0] !== rsp_chan.pair_class) begin
            $error("pair_class: expected %0d (%s), got %0d", pending_classes[0],
                   pending_classes[0].name(), rsp_chan.pair_class);
            mismatches++;
            void'(pending_classes.pop_front());
         end else begin
            void'(pending_classes.pop_front());
         end
      end
      if (!reset && req_chan.valid && !req_chan.ready) input_stalls++;
      if (reset || hold_off_cycles > 0) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready) ||
          (csr_chan.valid && csr_chan.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("FAIL paired_read_pair_classifier");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      reset                   = 1'b1;
      req_chan.valid          = 1'b0;
      req_chan.first_offset   = '0;
      req_chan.first_length   = '0;
      req_chan.first_forward  = 1'b0;
      req_chan.second_offset  = '0;
      req_chan.second_length  = '0;
      req_chan.second_forward = 1'b0;
      csr_chan.valid          = 1'b0;
      csr_chan.index          = '0;
      csr_chan.data           = '0;
      cfg_policy              = prpc_pkg::RESET_POLICY;
      cfg_max_fragment        = prpc_pkg::RESET_MAX_FRAGMENT;
      cfg_min_fragment        = prpc_pkg::RESET_MIN_FRAGMENT;
      cfg_expand              = prpc_pkg::RESET_EXPAND_TO_FIT;
      cfg_overlap_ok          = prpc_pkg::RESET_OVERLAP_ALLOWED;
      cfg_contain_ok          = prpc_pkg::RESET_CONTAIN_ALLOWED;
      cfg_dovetail_ok         = prpc_pkg::RESET_DOVETAIL_ALLOWED;
      send_idle_pct           = 7;
      recv_stall_pct          = 49;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_case_switches();
      test_unused_register_index();
      test_random_phases();
      test_backpressure();

      $display("Run covered %0d alignment pairs under %0d register settings (%0d csr transfers).",
               pairs_sent, settings_used + 1, csr_transfers);
      $display("%0d classes checked; request side stalled for %0d cycles.",
               classes_checked, input_stalls);
      if (mismatches == 0) begin
         $display("PASS paired_read_pair_classifier");
      end else begin
         $display("FAIL paired_read_pair_classifier");
      end
      $finish;
   end

endmodule
